[rtl/pud_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pud_pkg;

  localparam logic [7:0] PLUS_CHAR    = 8'h2B;
  localparam logic [7:0] PERCENT_CHAR = 8'h25;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [3:0] DIGIT_TEN    = 4'd10;

  // Most bytes that one input beat can produce.
  localparam int unsigned MAX_RES = 3;

  // Escape progress: nothing pending, percent held, percent and first digit held.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_t;

  // The decoded bytes settled by one input beat.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] data;
    logic [1:0]              cnt;
    logic                    last;
  } grp_t;

  function automatic logic is_hex(input logic [7:0] b);
    logic res;
    res = ((b >= 8'h30) && (b <= 8'h39)) ||
          ((b >= 8'h61) && (b <= 8'h66)) ||
          ((b >= 8'h41) && (b <= 8'h46));
    return res;
  endfunction

  // Nibble of a byte already known to be a hex digit.
  function automatic logic [3:0] nibble(input logic [7:0] b);
    logic [3:0] res;
    if (b <= 8'h39) begin
      res = b[3:0];
    end else begin
      res = b[3:0] - 4'd1 + DIGIT_TEN;
    end
    return res;
  endfunction

  // A plus decodes to a space; any other plain byte passes through.
  function automatic logic [7:0] plain_map(input logic [7:0] b);
    logic [7:0] res;
    res = (b == PLUS_CHAR) ? SPACE_CHAR : b;
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/pud_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

[rtl/pud_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

[rtl/pud_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module pud_front
  import pud_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   accept,
  input  wire logic [7:0] byte_in,
  input  wire logic   last_in,
  output grp_t        grp,
  output logic        push
);

  phase_t     phase, phase_next;
  logic [7:0] held, held_next;
  logic [1:0] n;
  logic [MAX_RES-1:0][7:0] r;

  always_comb begin
    phase_next = PH_IDLE;
    held_next  = held;
    n          = 2'd0;
    r          = '0;

    unique case (phase)
      PH_PCT: begin
        if (is_hex(byte_in)) begin
          phase_next = PH_DIG;
          held_next  = byte_in;
        end else begin
          r[0] = PERCENT_CHAR;
          if (byte_in == PERCENT_CHAR) begin
            phase_next = PH_PCT;
            n          = 2'd1;
          end else begin
            r[1] = plain_map(byte_in);
            n    = 2'd2;
          end
        end
      end
      PH_DIG: begin
        held_next = '0;
        if (is_hex(held) && is_hex(byte_in)) begin
          r[0] = {nibble(held), nibble(byte_in)};
          n    = 2'd1;
        end else begin
          r[0] = PERCENT_CHAR;
          r[1] = plain_map(held);
          if (byte_in == PERCENT_CHAR) begin
            phase_next = PH_PCT;
            n          = 2'd2;
          end else begin
            r[2] = plain_map(byte_in);
            n    = 2'd3;
          end
        end
      end
      default: begin
        if (byte_in == PERCENT_CHAR) begin
          phase_next = PH_PCT;
        end else begin
          r[0] = plain_map(byte_in);
          n    = 2'd1;
        end
      end
    endcase

    // An escape still open at the end of the string goes out literally.
    if (last_in) begin
      if (phase_next == PH_PCT) begin
        case (n)
          2'd0:    r[0] = PERCENT_CHAR;
          2'd1:    r[1] = PERCENT_CHAR;
          default: r[2] = PERCENT_CHAR;
        endcase
        n = n + 2'd1;
      end else if (phase_next == PH_DIG) begin
        r[0] = PERCENT_CHAR;
        r[1] = held_next;
        n    = 2'd2;
      end
      phase_next = PH_IDLE;
      held_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  assign grp.data = r;
  assign grp.cnt  = n;
  assign grp.last = last_in;
  assign push     = accept && (n != 2'd0);

endmodule

`default_nettype wire

[rtl/pud_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module pud_queue
  import pud_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire grp_t wr_grp,
  input  wire logic pop,
  output grp_t      head,
  output logic      empty,
  output logic      full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  grp_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] res;
    res = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    return res;
  endfunction

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/pud_serial.sv]
`timescale 1ns / 1ps
`default_nettype none

module pud_serial
  import pud_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire grp_t  head,
  input  wire logic  empty,
  output logic       pop,
  pud_out_if.source  dec
);

  logic [1:0] idx;
  logic       at_end;

  assign at_end    = (idx == head.cnt - 2'd1);
  assign dec.valid = !empty;
  assign dec.out_last = head.last && at_end;
  assign pop       = dec.valid && dec.ready && at_end;

  always_comb begin
    case (idx)
      2'd0:    dec.out_byte = head.data[0];
      2'd1:    dec.out_byte = head.data[1];
      default: dec.out_byte = head.data[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (dec.valid && dec.ready) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

[rtl/percent_url_decoder.sv]
// Each group is written into the group queue as its input beat is taken; dec offers
// its bytes from the queue head. Throughput: one input beat per cycle while the queue
// has room and each beat yields at most one byte; longer groups go out byte by byte.
// The group queue (QUEUE_DEPTH entries) absorbs those bursts; enc stalls only when full.
// Reset (rst, synchronous, active high) empties the queue and clears any pending escape.
`timescale 1ns / 1ps
`default_nettype none

module percent_url_decoder
  import pud_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  pud_in_if.sink    enc,
  pud_out_if.source dec
);

  // The front end owns the escape state. Every input beat it accepts is turned
  // into a group of zero to three decoded bytes in the same cycle; nonempty
  // groups are written into the queue.
  grp_t front_grp;
  logic front_push;
  logic accept;

  // Queue status and the group at its head.
  grp_t head;
  logic q_empty;
  logic q_full;
  logic q_pop;

  // A beat is taken whenever the queue has room, independent of whether the
  // serializer is currently stalled by the downstream sink.
  assign enc.ready = !q_full;
  assign accept    = enc.valid && enc.ready;

  pud_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .byte_in (enc.in_byte),
    .last_in (enc.in_last),
    .grp     (front_grp),
    .push    (front_push)
  );

  pud_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (front_push),
    .wr_grp (front_grp),
    .pop    (q_pop),
    .head   (head),
    .empty  (q_empty),
    .full   (q_full)
  );

  // The back end walks the head group one byte per output beat and retires
  // the group on its final byte, which also carries the end-of-string mark.
  pud_serial u_serial (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (q_empty),
    .pop   (q_pop),
    .dec   (dec)
  );

endmodule

`default_nettype wire

[rtl/pud_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module pud_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  // Nothing is offered right after reset, and input is taken at once.
  a_reset_clean: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("output valid or input stalled right after reset");

  // Output cannot appear unless something was accepted the cycle before.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !(in_valid && in_ready)) |=> !out_valid)
    else $error("output beat without a preceding input beat");

  // With nothing pending downstream, the queue cannot be full.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while no output pending");

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output beat changed");

endmodule

bind percent_url_decoder pud_checker u_pud_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (enc.valid),
  .in_ready  (enc.ready),
  .out_valid (dec.valid),
  .out_ready (dec.ready),
  .out_byte  (dec.out_byte),
  .out_last  (dec.out_last)
);

`default_nettype wire

[verif/percent_url_decoder_test.sv]
`timescale 1ns / 1ps

module percent_url_decoder_test;
  import pud_pkg::*;

  // The receiver holds off this long once, so the decoder fills up and stalls its input.
  localparam int HOLDOFF_CYCLES = 60;
  // The watchdog gives up after this many cycles in which no beat moves on either side.
  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 480;

  // One decoded byte as the output channel carries it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_beat_t;

  // Tracks the escape state of the decoder and keeps the decoded bytes still due.
  class decode_scoreboard;
    phase_t        escape;
    logic [7:0]    held_digit;
    logic [7:0]    settled[$];
    decoded_beat_t due_q[$];
    int            errors;
    int            checked;
    int            strings;
    int            bursts;

    function new();
      escape     = PH_IDLE;
      held_digit = 8'h00;
      errors     = 0;
      checked    = 0;
      strings    = 0;
      bursts     = 0;
    endfunction

    // Value of a hex digit in either case, or -1 for any other byte.
    static function int digit_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - int'("0");
      if (b >= "a" && b <= "f") return int'(b) - int'("a") + int'(DIGIT_TEN);
      if (b >= "A" && b <= "F") return int'(b) - int'("A") + int'(DIGIT_TEN);
      return -1;
    endfunction

    // Appends one byte to the bytes settled by the current beat.
    function void settle(logic [7:0] b);
      settled.insert(settled.size(), b);
    endfunction

    // A byte seen with no escape pending.
    function void plain_byte(logic [7:0] b);
      if (b == PLUS_CHAR) begin
        settle(SPACE_CHAR);
      end else if (b == PERCENT_CHAR) begin
        escape = PH_PCT;
      end else begin
        settle(b);
      end
    endfunction

    function void note_encoded(logic [7:0] b, logic last);
      int hi;
      int lo;
      settled.delete();
      case (escape)
        PH_PCT: begin
          if (digit_value(b) >= 0) begin
            held_digit = b;
            escape = PH_DIG;
          end else begin
            settle(PERCENT_CHAR);
            escape = PH_IDLE;
            plain_byte(b);
          end
        end
        PH_DIG: begin
          hi = digit_value(held_digit);
          lo = digit_value(b);
          escape = PH_IDLE;
          if (hi >= 0 && lo >= 0) begin
            settle(8'((hi << 4) | lo));
          end else begin
            settle(PERCENT_CHAR);
            plain_byte(held_digit);
            plain_byte(b);
          end
          held_digit = 8'h00;
        end
        default: begin
          escape = PH_IDLE;
          plain_byte(b);
        end
      endcase
      if (last) begin
        // An escape cut short by the end of the string goes out as it came in.
        if (escape == PH_PCT) begin
          settle(PERCENT_CHAR);
        end else if (escape == PH_DIG) begin
          settle(PERCENT_CHAR);
          settle(held_digit);
        end
        escape = PH_IDLE;
        held_digit = 8'h00;
        strings++;
      end
      if (settled.size() == MAX_RES) bursts++;
      foreach (settled[i]) begin
        due_q.insert(due_q.size(),
                     decoded_beat_t'{data: settled[i], last: last && (i == settled.size() - 1)});
      end
    endfunction

    function void check_decoded(logic [7:0] data, logic last);
      decoded_beat_t want;
      checked++;
      if (due_q.size() == 0) begin
        $display("%0t: decoded beat %02h last %0b arrived with nothing due", $time, data, last);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (data !== want.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: out_last expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  pud_in_if  enc ();
  pud_out_if dec ();

  percent_url_decoder dut (
    .clk (clk),
    .rst (rst),
    .enc (enc),
    .dec (dec)
  );

  decode_scoreboard sb;

  // Encoded bytes of the next random string, sent with in_last on the final one.
  logic [7:0] text_q[$];
  int         fed_items;
  int         out_beats;
  int         quiet_cycles;
  bit         no_gaps;
  bit         held_off;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Every beat that moves on either side is seen here at the rising edge. The input beat is
  // noted before the output beat is checked, so a beat that passed straight through would
  // still find its expectation waiting.
  always @(posedge clk) begin
    if (!rst) begin
      if (enc.valid && enc.ready) begin
        sb.note_encoded(enc.in_byte, enc.in_last);
      end
      if (dec.valid && dec.ready) begin
        sb.check_decoded(dec.out_byte, dec.out_last);
        out_beats++;
      end
      if ((enc.valid && enc.ready) || (dec.valid && dec.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  // The receiver drops ready at random, except in the no-gap stretch. Once enough decoded
  // bytes have come it holds off for a long run of cycles while the sender keeps offering
  // beats, which fills the group queue and has to push back on the input side.
  initial begin
    dec.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!held_off && out_beats >= 100) begin
        held_off = 1'b1;
        dec.ready = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      dec.ready = no_gaps || ($urandom_range(99) >= 31);
    end
  end

  // Offers one encoded byte, starting at a falling edge, and returns at the falling edge after
  // it was taken. Valid stays high into the next beat unless a gap is drawn.
  task automatic send_beat(input logic [7:0] b, input logic last);
    while (!no_gaps && $urandom_range(99) < 31) begin
      enc.valid = 1'b0;
      @(negedge clk);
    end
    enc.valid   = 1'b1;
    enc.in_byte = b;
    enc.in_last = last;
    @(posedge clk);
    while (!enc.ready) @(posedge clk);
    fed_items++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], i == s.len() - 1);
    end
  endtask

  task automatic send_queued();
    foreach (text_q[i]) begin
      send_beat(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  // Appends one byte to the text of the next random string.
  function automatic void add_text(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(int'("0") + v);
    return 8'(($urandom_range(1) ? int'("a") : int'("A")) + v - 10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (decode_scoreboard::digit_value(b) >= 0);
    return b;
  endfunction

  // Adds one piece of encoded text. Three in ten are well-formed escapes with random content;
  // the rest are plain bytes, plus signs and escapes that break off at either digit.
  task automatic add_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      add_text(PERCENT_CHAR);
      add_text(hex_char());
      add_text(hex_char());
    end else if (pick < 45) begin
      add_text(8'($urandom_range(255)));
    end else if (pick < 55) begin
      add_text(PLUS_CHAR);
    end else if (pick < 63) begin
      add_text(PERCENT_CHAR);
      add_text(hex_char());
      add_text(non_hex_char());
    end else if (pick < 71) begin
      add_text(PERCENT_CHAR);
      add_text(non_hex_char());
    end else if (pick < 78) begin
      add_text(PERCENT_CHAR);
    end else if (pick < 84) begin
      add_text(PERCENT_CHAR);
      add_text(hex_char());
    end else begin
      add_text(8'($urandom_range(int'("a"), int'("z"))));
    end
  endtask

  initial begin
    int random_start;
    sb           = new();
    fed_items    = 0;
    out_beats    = 0;
    quiet_cycles = 0;
    no_gaps      = 1'b0;
    held_off     = 1'b0;
    enc.valid    = 1'b0;
    enc.in_byte  = 8'h00;
    enc.in_last  = 1'b0;
    rst          = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed strings. The extreme byte values pass through untouched, a plus becomes a
    // space, and escapes are decoded with digits of either case.
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_text("+");
    send_text("%41");
    send_text("%fF");
    send_text("%00");
    // A percent sign whose next byte is not a digit goes out as is; here that next byte
    // starts an escape of its own.
    send_text("%%4a");
    // A bad second digit releases the percent sign and the first digit, then the byte itself,
    // which is three decoded bytes from one beat.
    send_text("%4z");
    send_text("%4+");
    // Escapes cut short by the end of the string.
    send_text("%");
    send_text("%9");

    // Random strings of one to five pieces. A stretch in the middle runs with no gaps on
    // either side so the decoder sees back-to-back beats for a while.
    random_start = fed_items;
    while (fed_items - random_start < RANDOM_ITEMS) begin
      no_gaps = (fed_items - random_start >= 150) && (fed_items - random_start < 270);
      repeat ($urandom_range(1, 5)) add_token();
      send_queued();
    end
    no_gaps = 1'b0;
    enc.valid = 1'b0;

    while (sb.outstanding() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d encoded bytes in %0d strings, with %0d three-byte bursts,",
             fed_items, sb.strings, sb.bursts);
    $display("and %0d decoded bytes were checked against the prediction.", sb.checked);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
